[rtl/vector3_normalize_macros.svh]
// Assertion macros shared by the vector3_normalize RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vn_pkg.sv]
// Shared types and constants for the vector3_normalize block.
// Depends on nothing; imported by the top level.
package vn_pkg;

    // Width of every payload field and default component width.
    localparam int unsigned VN_FIELD_W = 32;
    localparam int unsigned VN_COMP_W  = 32;

    // One input vector, signed Q16.16 components.
    typedef struct packed {
        logic signed [VN_FIELD_W-1:0] x_in;
        logic signed [VN_FIELD_W-1:0] y_in;
        logic signed [VN_FIELD_W-1:0] z_in;
    } t_vn_in;

    // One result: unit vector in Q2.30, magnitude in Q16.16, zero flag.
    typedef struct packed {
        logic signed [VN_FIELD_W-1:0] x_out;
        logic signed [VN_FIELD_W-1:0] y_out;
        logic signed [VN_FIELD_W-1:0] z_out;
        logic        [VN_FIELD_W-1:0] magnitude;
        logic                         zero_vector;
    } t_vn_out;

endpackage

[rtl/vn_sq_lane.sv]
// One component lane: absolute value, then exact square, two register stages.
// Depends on nothing; instantiated three times by the top level.
module vn_sq_lane #(
    parameter int unsigned W = 32
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_comp,
    output logic [W-1:0]   o_abs,
    output logic           o_neg,
    output logic [2*W-1:0] o_sq
);

    logic [W-1:0]   r_abs1;
    logic           r_neg1;
    logic [W-1:0]   r_abs2;
    logic           r_neg2;
    logic [2*W-1:0] r_sq2;
    logic [W-1:0]   n_abs1;

    // Two's complement magnitude; the most negative value fits unsigned.
    assign n_abs1 = i_comp[W-1] ? (~i_comp + W'(1)) : i_comp;

    // Stage one holds the magnitude, stage two the square.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs1 <= n_abs1;
            r_neg1 <= i_comp[W-1];
            r_abs2 <= r_abs1;
            r_neg2 <= r_neg1;
            r_sq2  <= (2*W)'(r_abs1) * (2*W)'(r_abs1);
        end
    end

    assign o_abs = r_abs2;
    assign o_neg = r_neg2;
    assign o_sq  = r_sq2;

endmodule

[rtl/vn_isqrt.sv]
// Pipelined integer square root, one root bit per stage, W stages.
// Depends on nothing; carries a side-band tag alongside the radicand.
module vn_isqrt #(
    parameter int unsigned W     = 32,
    parameter int unsigned TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2*W-1:0]   i_rad,
    input  logic [TAG_W-1:0] i_tag,
    output logic [W-1:0]     o_root,
    output logic [TAG_W-1:0] o_tag
);

    logic [W+1:0]   a_rem  [W+1];
    logic [W-1:0]   a_root [W+1];
    logic [2*W-1:0] a_rad  [W+1];
    logic [TAG_W-1:0] a_tag [W+1];

    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_rad[0]  = i_rad;
    assign a_tag[0]  = i_tag;

    // Each stage brings down two radicand bits and tries the next root bit.
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W+3:0]   w_cur;
        logic [W+3:0]   w_trial;
        logic           w_ge;
        logic [W+1:0]   r_rem;
        logic [W-1:0]   r_root;
        logic [2*W-1:0] r_rad;
        logic [TAG_W-1:0] r_tag;

        assign w_cur   = {a_rem[k], a_rad[k][2*W-1 -: 2]};
        assign w_trial = (W+4)'({a_root[k], 2'b01});
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? (W+2)'(w_cur - w_trial) : (W+2)'(w_cur);
                r_root <= {a_root[k][W-2:0], w_ge};
                r_rad  <= {a_rad[k][2*W-3:0], 2'b00};
                r_tag  <= a_tag[k];
            end
        end

        assign a_rem[k+1]  = r_rem;
        assign a_root[k+1] = r_root;
        assign a_rad[k+1]  = r_rad;
        assign a_tag[k+1]  = r_tag;
    end

    assign o_root = a_root[W];
    assign o_tag  = a_tag[W];

endmodule

[rtl/vn_div_lane.sv]
// Pipelined restoring divider for one unit component: (a << (W-2)) / m.
// Depends on nothing; a <= m holds, so the quotient needs W-1 stages.
module vn_div_lane #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_m,
    input  logic         i_neg,
    output logic [W-2:0] o_q,
    output logic [W-1:0] o_m,
    output logic         o_neg
);

    logic [W-1:0] a_rem [W];
    logic [W-2:0] a_q   [W];
    logic [W-1:0] a_m   [W];
    logic         a_neg [W];

    assign a_rem[0] = i_a;
    assign a_q[0]   = '0;
    assign a_m[0]   = i_m;
    assign a_neg[0] = i_neg;

    // The first stage decides the top quotient bit without a shift.
    for (genvar k = 0; k < W-1; k++) begin : g_stage
        logic [W:0]   w_t;
        logic         w_ge;
        logic [W-1:0] r_rem;
        logic [W-2:0] r_q;
        logic [W-1:0] r_m;
        logic         r_neg;

        if (k == 0) begin : g_first
            assign w_t = {1'b0, a_rem[k]};
        end else begin : g_rest
            assign w_t = {a_rem[k], 1'b0};
        end
        assign w_ge = (w_t >= {1'b0, a_m[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? W'(w_t - {1'b0, a_m[k]}) : W'(w_t);
                r_q   <= {a_q[k][W-3:0], w_ge};
                r_m   <= a_m[k];
                r_neg <= a_neg[k];
            end
        end

        assign a_rem[k+1] = r_rem;
        assign a_q[k+1]   = r_q;
        assign a_m[k+1]   = r_m;
        assign a_neg[k+1] = r_neg;
    end

    assign o_q   = a_q[W-1];
    assign o_m   = a_m[W-1];
    assign o_neg = a_neg[W-1];

endmodule

[rtl/vector3_normalize.sv]
// vector3_normalize: takes one vector per cycle while o_ready is high and
// returns its floor-root magnitude and its unit vector in Q2.30; it has
// two square stages, one sum stage, one root stage per magnitude bit, one
// divider stage per quotient bit and one output register, and the rate of
// one item per cycle is set by the fully pipelined root and divider stages;
// a two-entry output register with skid keeps the pipeline running while a
// finished result waits. Depends on vn_pkg, vn_sq_lane, vn_isqrt, vn_div_lane.
module vector3_normalize #(
    parameter int unsigned COMPONENT_WIDTH = vn_pkg::VN_COMP_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vn_pkg::t_vn_in i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output vn_pkg::t_vn_out o_data
);

    import vn_pkg::*;

    localparam int unsigned W     = COMPONENT_WIDTH;
    localparam int unsigned TAG_W = 3*W + 3;
    localparam int unsigned LAT   = 2*W + 2;

    logic           w_en;
    logic [W-1:0]   w_abs [3];
    logic           w_neg [3];
    logic [2*W-1:0] w_sq  [3];
    logic [W-1:0]   w_comp [3];
    logic [2*W-1:0] r_sum;
    logic [TAG_W-1:0] r_tag;
    logic [W-1:0]   w_root;
    logic [TAG_W-1:0] w_tag_out;
    logic [W-2:0]   w_q   [3];
    logic [W-1:0]   w_m   [3];
    logic           w_qneg [3];
    logic [LAT-1:0] r_vld;
    logic           w_take;
    t_vn_out        w_merged;
    logic [VN_FIELD_W-1:0] w_unit [3];
    logic [VN_FIELD_W-1:0] w_qext [3];
    logic           w_zero;
    t_vn_out        r_out;
    logic           r_out_valid;
    t_vn_out        r_skid;
    logic           r_skid_valid;

    // The pipeline moves whenever the skid entry is free.
    assign w_en    = !r_skid_valid;
    assign o_ready = w_en;

    assign w_comp[0] = i_data.x_in[W-1:0];
    assign w_comp[1] = i_data.y_in[W-1:0];
    assign w_comp[2] = i_data.z_in[W-1:0];

    // Square lanes, one per component.
    for (genvar l = 0; l < 3; l++) begin : g_sq
        vn_sq_lane #(.W(W)) u_sq (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_comp (w_comp[l]),
            .o_abs  (w_abs[l]),
            .o_neg  (w_neg[l]),
            .o_sq   (w_sq[l])
        );
    end

    // Sum of squares; it cannot overflow 2*W bits.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= w_sq[0] + w_sq[1] + w_sq[2];
            r_tag <= {w_neg[0], w_neg[1], w_neg[2], w_abs[0], w_abs[1], w_abs[2]};
        end
    end

    vn_isqrt #(.W(W), .TAG_W(TAG_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sum),
        .i_tag  (r_tag),
        .o_root (w_root),
        .o_tag  (w_tag_out)
    );

    // Divider lanes, one per component.
    for (genvar l = 0; l < 3; l++) begin : g_div
        vn_div_lane #(.W(W)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_tag_out[(2-l)*W +: W]),
            .i_m   (w_root),
            .i_neg (w_tag_out[3*W + 2 - l]),
            .o_q   (w_q[l]),
            .o_m   (w_m[l]),
            .o_neg (w_qneg[l])
        );
    end

    // Valid bits follow the items through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= LAT'({r_vld, i_valid});
        end
    end

    // Merge the lanes: apply signs and force zeros for the zero vector.
    assign w_zero = (w_m[0] == '0);
    for (genvar l = 0; l < 3; l++) begin : g_merge
        assign w_qext[l] = VN_FIELD_W'(w_q[l]);
        assign w_unit[l] = w_zero ? '0 : (w_qneg[l] ? (~w_qext[l] + 1'b1) : w_qext[l]);
    end

    always_comb begin
        w_merged.x_out       = w_unit[0];
        w_merged.y_out       = w_unit[1];
        w_merged.z_out       = w_unit[2];
        w_merged.magnitude   = VN_FIELD_W'(w_m[0]);
        w_merged.zero_vector = w_zero;
    end

    assign w_take = w_en && r_vld[LAT-1];

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_take;
            end
        end else if (w_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : w_merged;
        end else if (w_take) begin
            r_skid <= w_merged;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`include "vector3_normalize_macros.svh"

    `VN_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full while output empty")
    `VN_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, r_out_valid && !i_ready && w_take, r_skid_valid, "stalled result not parked in skid")
    `VN_ASSERT_NOW(a_zero_flag, i_clk, i_rst_n, o_valid, o_data.zero_vector == (o_data.magnitude == '0), "zero flag disagrees with magnitude")
    `VN_ASSERT_NOW(a_zero_units, i_clk, i_rst_n, o_valid && o_data.zero_vector, (o_data.x_out == '0) && (o_data.y_out == '0) && (o_data.z_out == '0), "zero vector with nonzero unit component")

endmodule
